// ===== sv/pjqd_pkg.sv =====
// ---------------------------------------------------------------------------
// pjqd_pkg
// Shared codes and types of the priority job dispatcher.
// ---------------------------------------------------------------------------
package pjqd_pkg;

   localparam int ACTION_W = 2;
   localparam int PRIO_W   = 2;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 2;

   localparam logic [ACTION_W-1:0] ACT_PUSH_NEW  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_WAIT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_POP       = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WAIT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NEW  = 2'd2;

   typedef struct packed {
      logic full;
      logic empty;
   } ring_stat_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KIND_W-1:0]   kind;
      logic                from_main;
   } pick_res_type;

endpackage

// ===== sv/pjqd_ring.sv =====
// ---------------------------------------------------------------------------
// pjqd_ring
// Ring FIFO with added/taken counts modulo twice the depth and a registered
// head read.
// ---------------------------------------------------------------------------
module pjqd_ring #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       rd_data,
   output pjqd_pkg::ring_stat_type stat
);
   import pjqd_pkg::*;

   localparam int CNT_W  = $clog2(2 * DEPTH);
   localparam int SLOT_W = $clog2(DEPTH);

   logic [CNT_W-1:0] added_ff, added_in;
   logic [CNT_W-1:0] taken_ff, taken_in;
   logic [CNT_W-1:0] occ;
   logic [WIDTH-1:0] rd_data_ff;
   logic [WIDTH-1:0] mem [DEPTH];

   function automatic logic [SLOT_W-1:0] slot_of(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] s;
      s = (c >= CNT_W'(DEPTH)) ? c - CNT_W'(DEPTH) : c;
      return s[SLOT_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
      return (c == CNT_W'(2 * DEPTH - 1)) ? '0 : c + 1'b1;
   endfunction

   // modular difference; adding the modulus keeps the wrapped case right
   always_comb begin
      if (added_ff >= taken_ff) begin
         occ = added_ff - taken_ff;
      end else begin
         occ = added_ff - taken_ff + CNT_W'(2 * DEPTH);
      end
   end

   assign stat.full  = (occ == CNT_W'(DEPTH));
   assign stat.empty = (added_ff == taken_ff);

   assign added_in = push ? bump(added_ff) : added_ff;
   assign taken_in = pop  ? bump(taken_ff) : taken_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         added_ff <= '0;
         taken_ff <= '0;
      end else begin
         added_ff <= added_in;
         taken_ff <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[slot_of(added_ff)] <= wr_data;
      end
      if (pop) begin
         rd_data_ff <= mem[slot_of(taken_ff)];
      end
   end

   assign rd_data = rd_data_ff;

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && stat.full))
      else $error("push into full ring");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && stat.empty))
      else $error("pop from empty ring");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !stat.empty)
      else $error("ring still empty after push");
`endif

endmodule

// ===== sv/pjqd_pick.sv =====
// ---------------------------------------------------------------------------
// pjqd_pick
// Decode one transfer into ring push/pop strobes and the result codes;
// strict priority across waiting, main-only and new rings.
// ---------------------------------------------------------------------------
module pjqd_pick #(
   parameter int NUM_LEVELS = 3,
   parameter int LVL_W      = 2
) (
   input  logic                          fire,
   input  logic [pjqd_pkg::ACTION_W-1:0] action,
   input  logic [LVL_W-1:0]              level,
   input  logic                          main_only,
   input  logic                          is_main,
   input  pjqd_pkg::ring_stat_type       new_stat  [NUM_LEVELS],
   input  pjqd_pkg::ring_stat_type       wait_stat [NUM_LEVELS],
   input  pjqd_pkg::ring_stat_type       main_stat,
   output logic [NUM_LEVELS-1:0]         new_push,
   output logic [NUM_LEVELS-1:0]         new_pop,
   output logic [NUM_LEVELS-1:0]         wait_push,
   output logic [NUM_LEVELS-1:0]         wait_pop,
   output logic                          main_push,
   output logic                          main_pop,
   output pjqd_pkg::pick_res_type        res,
   output logic [LVL_W-1:0]              pop_level
);
   import pjqd_pkg::*;

   logic             wait_any, new_any;
   logic [LVL_W-1:0] wait_lvl, new_lvl;

   // highest non-empty level wins: later iterations override
   always_comb begin
      wait_any = 1'b0;
      new_any  = 1'b0;
      wait_lvl = '0;
      new_lvl  = '0;
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
         if (!wait_stat[lv].empty) begin
            wait_any = 1'b1;
            wait_lvl = LVL_W'(lv);
         end
         if (!new_stat[lv].empty) begin
            new_any = 1'b1;
            new_lvl = LVL_W'(lv);
         end
      end
   end

   always_comb begin
      new_push      = '0;
      new_pop       = '0;
      wait_push     = '0;
      wait_pop      = '0;
      main_push     = 1'b0;
      main_pop      = 1'b0;
      res.status    = ST_OK;
      res.kind      = KIND_NONE;
      res.from_main = 1'b0;
      pop_level     = '0;
      case (action)
         ACT_PUSH_NEW: begin
            if (main_only) begin
               if (main_stat.full) begin
                  res.status = ST_FULL;
               end else begin
                  main_push = fire;
               end
            end else if (new_stat[level].full) begin
               res.status = ST_FULL;
            end else begin
               new_push[level] = fire;
            end
         end
         ACT_PUSH_WAIT: begin
            if (wait_stat[level].full) begin
               res.status = ST_FULL;
            end else begin
               wait_push[level] = fire;
            end
         end
         ACT_POP: begin
            if (wait_any) begin
               wait_pop[wait_lvl] = fire;
               res.kind           = KIND_WAIT;
               pop_level          = wait_lvl;
            end else if (is_main && !main_stat.empty) begin
               main_pop      = fire;
               res.kind      = KIND_NEW;
               res.from_main = 1'b1;
            end else if (new_any) begin
               new_pop[new_lvl] = fire;
               res.kind         = KIND_NEW;
               pop_level        = new_lvl;
            end else begin
               res.status = ST_EMPTY;
            end
         end
         default: begin
            res.status = ST_OK;
         end
      endcase
   end

endmodule

// ===== sv/priority_job_queue_dispatch.sv =====
// A request's response is valid in the cycle after it is accepted, and every
// request gives exactly one response; one request per cycle while not stalled.
// Ring heads are read in the accepting cycle into registered read data, which
// doubles as the response handle register.
// Reset clears all ring counts at once; ring contents are left as they are.
// ---------------------------------------------------------------------------
// priority_job_queue_dispatch
// Strict-priority dispatcher over per-level new and waiting job rings plus a
// main-worker-only ring; full pushes are rejected with a status.
// ---------------------------------------------------------------------------
module priority_job_queue_dispatch #(
   parameter int NUM_LEVELS  = 3,
   parameter int FIFO_DEPTH  = 256,
   parameter int HANDLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pjqd_pkg::ACTION_W-1:0] req_action,
   input  logic [pjqd_pkg::PRIO_W-1:0]   req_priority_req,
   input  logic                          req_main_only,
   input  logic [HANDLE_BITS-1:0]        req_job_handle,
   input  logic                          req_requester_is_main,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pjqd_pkg::STATUS_W-1:0] rsp_status,
   output logic [pjqd_pkg::KIND_W-1:0]   rsp_job_kind,
   output logic [HANDLE_BITS-1:0]        rsp_out_handle,
   output logic [pjqd_pkg::PRIO_W-1:0]   rsp_out_priority
);
   import pjqd_pkg::*;

   localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int MAIN_W = HANDLE_BITS + PRIO_W;

   logic fire;

   logic [LVL_W-1:0]          req_level;
   logic [LVL_W+PRIO_W-1:0]   req_level_ext;
   logic [NUM_LEVELS-1:0]     new_push, new_pop, wait_push, wait_pop;
   logic                      main_push, main_pop;
   ring_stat_type             new_stat  [NUM_LEVELS];
   ring_stat_type             wait_stat [NUM_LEVELS];
   ring_stat_type             main_stat;
   logic [HANDLE_BITS-1:0]    new_rd    [NUM_LEVELS];
   logic [HANDLE_BITS-1:0]    wait_rd   [NUM_LEVELS];
   logic [MAIN_W-1:0]         main_rd;
   pick_res_type              res;
   logic [LVL_W-1:0]          pop_level;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       status_ff;
   logic [KIND_W-1:0]         kind_ff;
   logic                      from_main_ff;
   logic [LVL_W-1:0]          level_ff;
   logic [LVL_W+PRIO_W-1:0]   level_ext;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign fire      = req_valid & ~req_stall;

   // saturate out-of-range priorities to the top level
   assign req_level = (req_priority_req >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                       : LVL_W'(req_priority_req);
   assign req_level_ext = {{PRIO_W{1'b0}}, req_level};

   pjqd_pick #(
      .NUM_LEVELS (NUM_LEVELS),
      .LVL_W      (LVL_W)
   ) u_pick (
      .fire       (fire),
      .action     (req_action),
      .level      (req_level),
      .main_only  (req_main_only),
      .is_main    (req_requester_is_main),
      .new_stat   (new_stat),
      .wait_stat  (wait_stat),
      .main_stat  (main_stat),
      .new_push   (new_push),
      .new_pop    (new_pop),
      .wait_push  (wait_push),
      .wait_pop   (wait_pop),
      .main_push  (main_push),
      .main_pop   (main_pop),
      .res        (res),
      .pop_level  (pop_level)
   );

   for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
      pjqd_ring #(
         .DEPTH (FIFO_DEPTH),
         .WIDTH (HANDLE_BITS)
      ) u_new (
         .clock   (clock),
         .reset   (reset),
         .push    (new_push[g]),
         .wr_data (req_job_handle),
         .pop     (new_pop[g]),
         .rd_data (new_rd[g]),
         .stat    (new_stat[g])
      );

      pjqd_ring #(
         .DEPTH (FIFO_DEPTH),
         .WIDTH (HANDLE_BITS)
      ) u_wait (
         .clock   (clock),
         .reset   (reset),
         .push    (wait_push[g]),
         .wr_data (req_job_handle),
         .pop     (wait_pop[g]),
         .rd_data (wait_rd[g]),
         .stat    (wait_stat[g])
      );
   end

   pjqd_ring #(
      .DEPTH (FIFO_DEPTH),
      .WIDTH (MAIN_W)
   ) u_main (
      .clock   (clock),
      .reset   (reset),
      .push    (main_push),
      .wr_data ({req_level_ext[PRIO_W-1:0], req_job_handle}),
      .pop     (main_pop),
      .rd_data (main_rd),
      .stat    (main_stat)
   );

   // hold the response while stalled
   assign rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff    <= res.status;
         kind_ff      <= res.kind;
         from_main_ff <= res.from_main;
         level_ff     <= pop_level;
      end
   end

   assign level_ext = {{PRIO_W{1'b0}}, level_ff};

   always_comb begin
      case (kind_ff)
         KIND_WAIT: begin
            rsp_out_handle   = wait_rd[level_ff];
            rsp_out_priority = level_ext[PRIO_W-1:0];
         end
         KIND_NEW: begin
            if (from_main_ff) begin
               rsp_out_handle   = main_rd[HANDLE_BITS-1:0];
               rsp_out_priority = main_rd[HANDLE_BITS +: PRIO_W];
            end else begin
               rsp_out_handle   = new_rd[level_ff];
               rsp_out_priority = level_ext[PRIO_W-1:0];
            end
         end
         default: begin
            rsp_out_handle   = '0;
            rsp_out_priority = '0;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_job_kind = kind_ff;

`ifndef SYNTHESIS
   a_transfer_responds: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("accepted request produced no response");

   a_pop_status_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_job_kind == KIND_WAIT || rsp_job_kind == KIND_NEW))
         |-> (rsp_status == ST_OK))
      else $error("popped job with non-ok status");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority job dispatcher. Directed requests hit
// the field extremes and the odd cases. Random traffic follows: mixed pushes
// and pops, a long fill of one ring until pushes are rejected, and a
// pop-heavy drain. Every response is predicted from a ring-level copy of the
// queues and compared field by field, in order.
// ---------------------------------------------------------------------------

class dispatch_tracker;
   localparam int NUM_LEVELS = 3;
   localparam int FIFO_DEPTH = 256;
   localparam int WAIT_BASE  = NUM_LEVELS;
   localparam int MAIN_RING  = 2 * NUM_LEVELS;
   localparam int RING_COUNT = 2 * NUM_LEVELS + 1;

   typedef struct packed {
      logic [pjqd_pkg::STATUS_W-1:0] status;
      logic [pjqd_pkg::KIND_W-1:0]   kind;
      logic [15:0]                   handle;
      logic [pjqd_pkg::PRIO_W-1:0]   prio;
   } reply_type;

   // rings 0..NUM_LEVELS-1 hold new jobs, then waiting jobs, then main-only
   logic [15:0]                 ring_handle [RING_COUNT][FIFO_DEPTH];
   logic [pjqd_pkg::PRIO_W-1:0] ring_prio   [RING_COUNT][FIFO_DEPTH];
   int                          ring_head   [RING_COUNT];
   int                          ring_fill   [RING_COUNT];
   reply_type                   owed_replies [$];

   int error_count   = 0;
   int request_count = 0;
   int full_count    = 0;
   int empty_count   = 0;
   int resumed_count = 0;
   int started_count = 0;

   function new();
      foreach (ring_head[r]) begin
         ring_head[r] = 0;
         ring_fill[r] = 0;
      end
   endfunction

   function int pending();
      return owed_replies.size();
   endfunction

   task report(string what, logic [31:0] want, logic [31:0] got);
      error_count++;
      $display("%0t MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
   endtask

   function reply_type take_head(int ring, logic [pjqd_pkg::KIND_W-1:0] kind);
      reply_type r;
      r.status = pjqd_pkg::ST_OK;
      r.kind   = kind;
      r.handle = ring_handle[ring][ring_head[ring]];
      r.prio   = ring_prio[ring][ring_head[ring]];
      ring_head[ring] = (ring_head[ring] + 1) % FIFO_DEPTH;
      ring_fill[ring]--;
      return r;
   endfunction

   function void note_request(logic [pjqd_pkg::ACTION_W-1:0] action,
                              logic [pjqd_pkg::PRIO_W-1:0] prio_req, logic main_only,
                              logic [15:0] handle, logic is_main);
      reply_type r;
      int        lvl;
      int        ring;
      int        slot;
      bit        found;
      r     = '0;
      found = 1'b0;
      // out-of-range priority saturates to the top level
      lvl = (prio_req >= NUM_LEVELS) ? NUM_LEVELS - 1 : prio_req;
      if (action == pjqd_pkg::ACT_PUSH_NEW || action == pjqd_pkg::ACT_PUSH_WAIT) begin
         if (action == pjqd_pkg::ACT_PUSH_WAIT)
            ring = WAIT_BASE + lvl;
         else if (main_only)
            ring = MAIN_RING;
         else
            ring = lvl;
         if (ring_fill[ring] == FIFO_DEPTH) begin
            r.status = pjqd_pkg::ST_FULL;
            full_count++;
         end else begin
            slot = (ring_head[ring] + ring_fill[ring]) % FIFO_DEPTH;
            ring_handle[ring][slot] = handle;
            ring_prio[ring][slot]   = lvl[pjqd_pkg::PRIO_W-1:0];
            ring_fill[ring]++;
         end
      end else if (action == pjqd_pkg::ACT_POP) begin
         for (int l = NUM_LEVELS - 1; l >= 0 && !found; l--) begin
            if (ring_fill[WAIT_BASE + l] != 0) begin
               r     = take_head(WAIT_BASE + l, pjqd_pkg::KIND_WAIT);
               found = 1'b1;
            end
         end
         if (!found && is_main && ring_fill[MAIN_RING] != 0) begin
            r     = take_head(MAIN_RING, pjqd_pkg::KIND_NEW);
            found = 1'b1;
         end
         for (int l = NUM_LEVELS - 1; l >= 0 && !found; l--) begin
            if (ring_fill[l] != 0) begin
               r     = take_head(l, pjqd_pkg::KIND_NEW);
               found = 1'b1;
            end
         end
         if (!found) begin
            r.status = pjqd_pkg::ST_EMPTY;
            empty_count++;
         end else if (r.kind == pjqd_pkg::KIND_WAIT) begin
            resumed_count++;
         end else begin
            started_count++;
         end
      end
      request_count++;
      owed_replies.push_back(r);
   endfunction

   task check_response(logic [pjqd_pkg::STATUS_W-1:0] status,
                       logic [pjqd_pkg::KIND_W-1:0] kind, logic [15:0] handle,
                       logic [pjqd_pkg::PRIO_W-1:0] prio);
      reply_type want;
      if (owed_replies.size() == 0) begin
         report("response with no request outstanding", 0,
                32'({status, kind, handle, prio}));
         return;
      end
      want = owed_replies.pop_front();
      if (status !== want.status) report("status", 32'(want.status), 32'(status));
      if (kind !== want.kind) report("job_kind", 32'(want.kind), 32'(kind));
      if (handle !== want.handle) report("out_handle", 32'(want.handle), 32'(handle));
      if (prio !== want.prio) report("out_priority", 32'(want.prio), 32'(prio));
   endtask
endclass

module tb_top;
   import pjqd_pkg::*;

   localparam int NUM_LEVELS     = 3;
   localparam int FIFO_DEPTH     = 256;
   localparam int HANDLE_BITS    = 16;
   localparam int CLK_PERIOD     = 10;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef enum int {TGT_NEW, TGT_WAIT, TGT_MAIN} fill_target_type;

   logic                   clock                 = 1'b0;
   logic                   reset                 = 1'b1;
   logic                   req_valid             = 1'b0;
   logic [ACTION_W-1:0]    req_action            = '0;
   logic [PRIO_W-1:0]      req_priority_req      = '0;
   logic                   req_main_only         = 1'b0;
   logic [HANDLE_BITS-1:0] req_job_handle        = '0;
   logic                   req_requester_is_main = 1'b0;
   logic                   rsp_stall             = 1'b0;
   logic                   req_stall;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [KIND_W-1:0]      rsp_job_kind;
   logic [HANDLE_BITS-1:0] rsp_out_handle;
   logic [PRIO_W-1:0]      rsp_out_priority;

   int send_idle_pct  = 23;
   int recv_stall_pct = 50;
   int hold_request   = 0;
   int hold_left      = 0;

   dispatch_tracker sb;

   priority_job_queue_dispatch #(
      .NUM_LEVELS (NUM_LEVELS),
      .FIFO_DEPTH (FIFO_DEPTH),
      .HANDLE_BITS(HANDLE_BITS)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_priority_req     (req_priority_req),
      .req_main_only        (req_main_only),
      .req_job_handle       (req_job_handle),
      .req_requester_is_main(req_requester_is_main),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_job_kind         (rsp_job_kind),
      .rsp_out_handle       (rsp_out_handle),
      .rsp_out_priority     (rsp_out_priority)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("RESULT: ERROR");
      $finish;
   end

   // Response side: check each transfer, then pick the next stall value.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_status, rsp_job_kind, rsp_out_handle, rsp_out_priority);
         if (hold_left == 0 && hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   task automatic send_request(input logic [ACTION_W-1:0] action,
                               input logic [PRIO_W-1:0] prio, input logic main_only,
                               input logic [HANDLE_BITS-1:0] handle, input logic is_main);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 8)
         gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_action            <= action;
      req_priority_req      <= prio;
      req_main_only         <= main_only;
      req_job_handle        <= handle;
      req_requester_is_main <= is_main;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(action, prio, main_only, handle, is_main);
   endtask

   task automatic send_mixed(input int pop_pct);
      logic [ACTION_W-1:0] action;
      int                  pick;
      pick = $urandom_range(99);
      if (pick < 5)
         action = ACT_UNUSED;
      else if (pick < 5 + pop_pct)
         action = ACT_POP;
      else if ($urandom_range(1) == 0)
         action = ACT_PUSH_NEW;
      else
         action = ACT_PUSH_WAIT;
      send_request(action, PRIO_W'($urandom_range(3)), $urandom_range(3) == 0,
                   HANDLE_BITS'($urandom_range(65535)), 1'($urandom_range(1)));
   endtask

   task automatic send_fill(input fill_target_type target, input int target_lvl);
      logic [PRIO_W-1:0] prio;
      prio = PRIO_W'(target_lvl);
      // the top level is also reached through the saturating code
      if (target_lvl == NUM_LEVELS - 1 && $urandom_range(3) == 0)
         prio = '1;
      case (target)
         TGT_NEW: begin
            send_request(ACT_PUSH_NEW, prio, 1'b0, HANDLE_BITS'($urandom_range(65535)),
                         1'($urandom_range(1)));
         end
         TGT_WAIT: begin
            send_request(ACT_PUSH_WAIT, prio, 1'($urandom_range(1)),
                         HANDLE_BITS'($urandom_range(65535)), 1'($urandom_range(1)));
         end
         default: begin
            send_request(ACT_PUSH_NEW, PRIO_W'($urandom_range(3)), 1'b1,
                         HANDLE_BITS'($urandom_range(65535)), 1'($urandom_range(1)));
         end
      endcase
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic wait_drained();
      int spin;
      spin = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 && spin < 5000) begin
         @(posedge clock);
         spin++;
      end
   endtask

   initial begin
      fill_target_type target;
      int              target_lvl;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty pops and the unused action on a fresh block
      send_request(ACT_POP, 2'd0, 1'b0, 16'h0000, 1'b0);
      send_request(ACT_POP, 2'd3, 1'b1, 16'hFFFF, 1'b1);
      send_request(ACT_UNUSED, 2'd0, 1'b0, 16'h0000, 1'b0);
      // pushes: handle extremes, saturated priority, ignored flags
      send_request(ACT_PUSH_NEW, 2'd0, 1'b0, 16'h0000, 1'b0);
      send_request(ACT_PUSH_NEW, 2'd3, 1'b0, 16'hFFFF, 1'b1);
      send_request(ACT_PUSH_NEW, 2'd1, 1'b0, 16'h1234, 1'b0);
      send_request(ACT_PUSH_WAIT, 2'd0, 1'b1, 16'hA5A5, 1'b1);
      send_request(ACT_PUSH_WAIT, 2'd2, 1'b0, 16'h5A5A, 1'b0);
      send_request(ACT_PUSH_NEW, 2'd3, 1'b1, 16'h8001, 1'b0);
      send_request(ACT_PUSH_NEW, 2'd0, 1'b1, 16'h7FFE, 1'b1);
      send_request(ACT_UNUSED, 2'd3, 1'b1, 16'hFFFF, 1'b1);
      // pops walk the priority order: waiting, main-only, then new jobs
      send_request(ACT_POP, 2'd0, 1'b0, 16'h0000, 1'b1);
      send_request(ACT_POP, 2'd3, 1'b1, 16'hFFFF, 1'b0);
      send_request(ACT_POP, 2'd0, 1'b0, 16'h0000, 1'b0);
      send_request(ACT_POP, 2'd0, 1'b0, 16'h0000, 1'b1);
      send_request(ACT_POP, 2'd0, 1'b0, 16'h0000, 1'b1);
      send_request(ACT_POP, 2'd0, 1'b0, 16'h0000, 1'b1);
      send_request(ACT_POP, 2'd0, 1'b0, 16'h0000, 1'b0);
      send_request(ACT_POP, 2'd0, 1'b0, 16'h0000, 1'b1);

      repeat (150) send_mixed(35);
      hold_request = 60;
      repeat (150) send_mixed(35);
      wait_drained();

      // fill one ring past full, with a little unrelated traffic mixed in
      send_idle_pct  = 50;
      recv_stall_pct = 23;
      target         = fill_target_type'($urandom_range(2));
      target_lvl     = $urandom_range(NUM_LEVELS - 1);
      repeat (300) begin
         if ($urandom_range(11) == 0)
            send_mixed(35);
         else
            send_fill(target, target_lvl);
      end
      wait_drained();

      // drain hard, then mixed traffic, with no random idling on either side
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (150) send_mixed(85);
      hold_request = 80;
      repeat (150) send_mixed(85);
      repeat (150) send_mixed(35);
      wait_drained();
      repeat (4) @(posedge clock);

      if (sb.pending() != 0)
         sb.report("responses never received", sb.pending(), 0);
      $display("Covered %0d requests: %0d pushes rejected on a full ring, %0d empty pops.",
               sb.request_count, sb.full_count, sb.empty_count);
      $display("Dispatched %0d resumed waiting jobs and %0d new jobs; filled %s level %0d.",
               sb.resumed_count, sb.started_count, target.name(), target_lvl);
      if (sb.error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
